FILE: design/tctb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tctb_pkg;

    localparam int SLOTS         = 4;
    localparam int SAMPLE_BITS   = 12;
    localparam int TIME_BITS     = 32;
    localparam int HISTORY_DEPTH = 3;

    // field widths fixed by the item layout
    localparam int BAND_BITS = 12;
    localparam int OP_BITS   = 2;
    localparam int SLOT_BITS = 2;
    localparam int TIDX_BITS = 2;

    localparam int THR_BITS      = SLOTS * SAMPLE_BITS;
    localparam int CFG_DATA_BITS = THR_BITS;
    localparam int CFG_IDX_BITS  = 3;

    localparam int CMP_BITS = ((SAMPLE_BITS > BAND_BITS) ? SAMPLE_BITS : BAND_BITS) + 1;
    localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HIST_AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int HSUM_W   = ((HIST_AW > TIDX_BITS) ? HIST_AW : TIDX_BITS) + 1;

    localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLDS  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_BAND  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLES     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RISING      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GPIO_ACTION = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GPIO_LEVELS = 3'd5;

    typedef struct packed {
        logic [SLOTS-1:0] fire;
        logic [SLOTS-1:0] arm;
    } tctb_eval_t;

endpackage

`default_nettype wire

FILE: design/tctb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tctb_in_if;
    import tctb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     op;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   timestamp;
    logic [SLOTS-1:0]       clear_mask;
    logic [SLOT_BITS-1:0]   slot;
    logic [TIDX_BITS-1:0]   time_index;

    modport source (output valid, op, sample, timestamp, clear_mask, slot, time_index,
                    input ready);
    modport sink (input valid, op, sample, timestamp, clear_mask, slot, time_index,
                  output ready);
endinterface

interface tctb_out_if;
    import tctb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SLOTS-1:0]     triggered_flags;
    logic [SLOTS-1:0]     fired_mask;
    logic                 gpio_write;
    logic                 gpio_level;
    logic [TIME_BITS-1:0] event_time;

    modport source (output valid, triggered_flags, fired_mask, gpio_write, gpio_level,
                    event_time, input ready);
    modport sink (input valid, triggered_flags, fired_mask, gpio_write, gpio_level,
                  event_time, output ready);
endinterface

`default_nettype wire

FILE: design/tctb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tctb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

FILE: design/tctb_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module tctb_eval (
    input  wire logic [tctb_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [tctb_pkg::THR_BITS-1:0]    thresholds,
    input  wire logic [tctb_pkg::BAND_BITS-1:0]   band,
    input  wire logic [tctb_pkg::SLOTS-1:0]       enables,
    input  wire logic [tctb_pkg::SLOTS-1:0]       rising,
    input  wire logic [tctb_pkg::SLOTS-1:0]       armed,
    output tctb_pkg::tctb_eval_t                  result
);
    import tctb_pkg::*;

    logic [CMP_BITS-1:0] smp_ext;
    logic [CMP_BITS-1:0] band_ext;

    assign smp_ext  = CMP_BITS'(sample);
    assign band_ext = CMP_BITS'(band);

    // all slots compare side by side, with one spare bit so the sums never wrap
    always_comb
    begin
        logic [CMP_BITS-1:0] thr;
        logic                above;
        logic                below;
        result = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            thr   = CMP_BITS'(thresholds[s*SAMPLE_BITS +: SAMPLE_BITS]);
            above = smp_ext > (thr + band_ext);
            below = (smp_ext + band_ext) < thr;
            if (enables[s])
            begin
                if (armed[s])
                begin
                    result.fire[s] = rising[s] ? above : below;
                end
                else
                begin
                    result.arm[s] = rising[s] ? below : above;
                end
            end
        end
    end
endmodule

`default_nettype wire

FILE: design/threshold_crossing_trigger_bank.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           payload
// items     in   valid / ready       op, sample, timestamp, clear_mask, slot, time_index
// results   out  valid / ready       triggered_flags, fired_mask, gpio_write, gpio_level,
//                                    event_time
// cfg       in   cfg_we              cfg_index, cfg_data (write only)
//
// one word per cycle sustained while results are taken; a word moves to the read stage,
// where the per-slot history ram is read, and then to the output register.
// history lives in one ring buffer ram per slot with a head pointer and a fill count,
// so reset needs no clearing pass; unfilled entries read as zero.
// a stalled result holds in the output register while one more word can enter.

module threshold_crossing_trigger_bank (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tctb_in_if.sink                                items,
    tctb_out_if.source                             results,
    input  wire logic                              cfg_we,
    input  wire logic [tctb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [tctb_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import tctb_pkg::*;

    // configuration
    logic [THR_BITS-1:0]  thr_reg,   thr_next;
    logic [BAND_BITS-1:0] band_reg,  band_next;
    logic [SLOTS-1:0]     en_reg,    en_next;
    logic [SLOTS-1:0]     rise_reg,  rise_next;
    logic [SLOTS-1:0]     gact_reg,  gact_next;
    logic [SLOTS-1:0]     glev_reg,  glev_next;

    // slot state
    logic [SLOTS-1:0]     armed_reg, armed_next;
    logic [SLOTS-1:0]     trig_reg,  trig_next;
    logic [HIST_AW-1:0]   head_reg [SLOTS];
    logic [HIST_AW-1:0]   head_dec [SLOTS];
    logic [HIST_CW-1:0]   cnt_reg  [SLOTS];

    // read stage and output register
    logic                 s1_valid_reg, s1_valid_next;
    logic [SLOTS-1:0]     s1_trig_reg;
    logic [SLOTS-1:0]     s1_fired_reg;
    logic                 s1_gw_reg;
    logic                 s1_gl_reg;
    logic                 s1_hit_reg;
    logic [SLOT_AW-1:0]   s1_sel_reg;
    logic                 o_valid_reg, o_valid_next;
    logic [SLOTS-1:0]     o_trig_reg;
    logic [SLOTS-1:0]     o_fired_reg;
    logic                 o_gw_reg;
    logic                 o_gl_reg;
    logic [TIME_BITS-1:0] o_time_reg;

    logic                 accept_in;
    logic                 s1_adv;
    logic                 is_sample;
    logic [SLOTS-1:0]     fired;
    logic                 gw;
    logic                 gl;
    tctb_eval_t           ev;

    logic [SLOT_AW-1:0]   rd_sel;
    logic                 rd_hit;
    logic [HIST_AW-1:0]   rd_addr;
    logic [HSUM_W-1:0]    rd_sum;

    logic                 bank_we [SLOTS];
    logic                 bank_re [SLOTS];
    logic [TIME_BITS-1:0] bank_q  [SLOTS];

    assign s1_adv      = s1_valid_reg && (!o_valid_reg || results.ready);
    assign items.ready = !s1_valid_reg || s1_adv;
    assign accept_in   = items.valid && items.ready;
    assign is_sample   = (items.op == OP_SAMPLE);

    tctb_eval u_eval (
        .sample     (items.sample),
        .thresholds (thr_reg),
        .band       (band_reg),
        .enables    (en_reg),
        .rising     (rise_reg),
        .armed      (armed_reg),
        .result     (ev)
    );

    assign fired = is_sample ? ev.fire : '0;

    // highest-numbered firing slot with a gpio action sets the level
    always_comb
    begin
        gw = 1'b0;
        gl = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (fired[s] && gact_reg[s])
            begin
                gw = 1'b1;
                gl = glev_reg[s];
            end
        end
    end

    always_comb
    begin
        trig_next  = trig_reg;
        armed_next = armed_reg;
        if (accept_in)
        begin
            case (items.op)
                OP_SAMPLE:
                begin
                    trig_next  = trig_reg | ev.fire;
                    armed_next = (armed_reg & ~ev.fire) | ev.arm;
                end
                OP_CLEAR:
                begin
                    trig_next = trig_reg & ~items.clear_mask;
                end
                default:
                begin
                    trig_next = trig_reg;
                end
            endcase
        end
        if (cfg_we && (cfg_index == REG_THRESHOLDS))
        begin
            armed_next = '0;
        end
    end

    always_comb
    begin
        thr_next  = thr_reg;
        band_next = band_reg;
        en_next   = en_reg;
        rise_next = rise_reg;
        gact_next = gact_reg;
        glev_next = glev_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLDS:  thr_next  = cfg_data[THR_BITS-1:0];
                REG_NOISE_BAND:  band_next = cfg_data[BAND_BITS-1:0];
                REG_ENABLES:     en_next   = cfg_data[SLOTS-1:0];
                REG_RISING:      rise_next = cfg_data[SLOTS-1:0];
                REG_GPIO_ACTION: gact_next = cfg_data[SLOTS-1:0];
                REG_GPIO_LEVELS: glev_next = cfg_data[SLOTS-1:0];
                default:         thr_next  = thr_reg;
            endcase
        end
    end

    // history read: newest entry sits at the head, older ones follow it around the ring
    assign rd_sel  = items.slot[SLOT_AW-1:0];
    assign rd_hit  = (items.op == OP_READ)
                     && (32'(items.slot) < SLOTS)
                     && (32'(items.time_index) < HISTORY_DEPTH)
                     && (32'(items.time_index) < 32'(cnt_reg[rd_sel]));

    always_comb
    begin
        rd_sum = HSUM_W'(head_reg[rd_sel]) + HSUM_W'(items.time_index);
        if (rd_sum >= HSUM_W'(HISTORY_DEPTH))
        begin
            rd_sum = rd_sum - HSUM_W'(HISTORY_DEPTH);
        end
        rd_addr = rd_sum[HIST_AW-1:0];
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_bank
        assign head_dec[g] = (head_reg[g] == '0) ? HIST_AW'(HISTORY_DEPTH - 1)
                                                 : head_reg[g] - 1'b1;
        assign bank_we[g]  = accept_in && fired[g];
        assign bank_re[g]  = accept_in && rd_hit && (rd_sel == SLOT_AW'(g));

        tctb_ram #(
            .WIDTH (TIME_BITS),
            .DEPTH (HISTORY_DEPTH)
        ) u_hist (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (head_dec[g]),
            .wdata (items.timestamp),
            .re    (bank_re[g]),
            .raddr (rd_addr),
            .rdata (bank_q[g])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                head_reg[g] <= '0;
                cnt_reg[g]  <= '0;
            end
            else if (bank_we[g])
            begin
                head_reg[g] <= head_dec[g];
                if (32'(cnt_reg[g]) < HISTORY_DEPTH)
                begin
                    cnt_reg[g] <= cnt_reg[g] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (s1_adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= '0;
            band_reg     <= '0;
            en_reg       <= '0;
            rise_reg     <= '0;
            gact_reg     <= '0;
            glev_reg     <= '0;
            armed_reg    <= '0;
            trig_reg     <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            thr_reg      <= thr_next;
            band_reg     <= band_next;
            en_reg       <= en_next;
            rise_reg     <= rise_next;
            gact_reg     <= gact_next;
            glev_reg     <= glev_next;
            armed_reg    <= armed_next;
            trig_reg     <= trig_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_trig_reg  <= trig_next;
            s1_fired_reg <= fired;
            s1_gw_reg    <= gw;
            s1_gl_reg    <= gl;
            s1_hit_reg   <= rd_hit;
            s1_sel_reg   <= rd_sel;
        end
        // ram data holds until the next read, which only comes with this move
        if (s1_adv)
        begin
            o_trig_reg  <= s1_trig_reg;
            o_fired_reg <= s1_fired_reg;
            o_gw_reg    <= s1_gw_reg;
            o_gl_reg    <= s1_gl_reg;
            o_time_reg  <= s1_hit_reg ? bank_q[s1_sel_reg] : '0;
        end
    end

    assign results.valid           = o_valid_reg;
    assign results.triggered_flags = o_trig_reg;
    assign results.fired_mask      = o_fired_reg;
    assign results.gpio_write      = o_gw_reg;
    assign results.gpio_level      = o_gl_reg;
    assign results.event_time      = o_time_reg;
endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import tctb_pkg::*;

    localparam logic [OP_BITS-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam int DIR_ROWS    = 34;
    localparam int RAND_PHASES = 8;
    localparam int RAND_WORDS  = 100;

    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   timestamp;
        logic [SLOTS-1:0]       clear_mask;
        logic [SLOT_BITS-1:0]   slot;
        logic [TIDX_BITS-1:0]   time_index;
    } word_t;

    typedef struct packed {
        logic [SLOTS-1:0]     triggered_flags;
        logic [SLOTS-1:0]     fired_mask;
        logic                 gpio_write;
        logic                 gpio_level;
        logic [TIME_BITS-1:0] event_time;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } reg_write_t;

    typedef struct packed {
        logic       is_write;
        reg_write_t wr;
        word_t      w;
        logic       pinned;
        result_t    want;
    } dir_row_t;

    typedef struct packed {
        logic    pinned;
        result_t want;
    } pin_t;

    localparam reg_write_t NO_WRITE    = '0;
    localparam word_t      NO_WORD     = '0;
    localparam result_t    IDLE_RESULT = {4'h0, 4'h0, 1'b0, 1'b0, 32'h0};

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    tctb_in_if  items_if ();
    tctb_out_if results_if ();

    threshold_crossing_trigger_bank u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies and slot state of the predictor
    logic [THR_BITS-1:0]  thr_bits;
    logic [BAND_BITS-1:0] band_w;
    logic [SLOTS-1:0]     en_bits;
    logic [SLOTS-1:0]     rise_bits;
    logic [SLOTS-1:0]     gpio_act_bits;
    logic [SLOTS-1:0]     gpio_lvl_bits;
    logic [SLOTS-1:0]     armed_slots;
    logic [SLOTS-1:0]     sticky_flags;
    logic [TIME_BITS-1:0] fire_times [SLOTS][HISTORY_DEPTH];

    result_t expected_results [$];
    pin_t    pinned_q [$];

    int mismatches = 0;
    int n_words    = 0;
    int n_fired    = 0;
    int n_reads    = 0;
    int n_writes   = 0;
    int tx_gap_pct = 20;
    int rx_stall_pct = 20;
    int rx_wait    = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // registers at reset: nothing enabled, nothing recorded
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, 4'h0, 2'd0, 2'd0}, 1'b1, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'h000, 32'h0000_0000, 4'h0, 2'd0, 2'd0}, 1'b1, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd3, 2'd2}, 1'b1, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_CLEAR, 12'h000, 32'h0000_0000, 4'hF, 2'd0, 2'd0}, 1'b1, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 4'hF, 2'd3, 2'd3}, 1'b1, IDLE_RESULT},
        // slot 0 at zero and slot 1 at full scale can never arm or fire
        {1'b1, {REG_THRESHOLDS, 48'h064_800_FFF_000}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_NOISE_BAND, 48'h0000_0000_00C8}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_ENABLES, 48'h0000_0000_000F}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_RISING, 48'h0000_0000_0005}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_GPIO_ACTION, 48'h0000_0000_000F}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_GPIO_LEVELS, 48'h0000_0000_000A}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'h000, 32'h0000_0001, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'hFFF, 32'h0000_0002, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd2, 2'd0}, 1'b0, IDLE_RESULT},
        // direction flips while arms are kept
        {1'b1, {REG_NOISE_BAND, 48'h0000_0000_0000}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_RISING, 48'h0000_0000_000A}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'h000, 32'h0000_0000, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'hFFF, 32'h0000_0005, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd3, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd3, 2'd1}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd3, 2'd3}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_CLEAR, 12'h000, 32'h0000_0000, 4'h5, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_UNUSED, 12'h000, 32'h0000_0000, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        // disabled slots hold their arms; spare indexes are dropped
        {1'b1, {REG_ENABLES, 48'h0000_0000_0003}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_GPIO_ACTION, 48'hFFFF_FFFF_FFF0}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_SPARE_LO, 48'hFFFF_FFFF_FFFF}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b1, {REG_SPARE_HI, 48'h0000_0000_0000}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'h000, 32'h0000_0006, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_CLEAR, 12'h000, 32'h0000_0000, 4'hF, 2'd0, 2'd0}, 1'b1, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd1, 2'd3}, 1'b1, IDLE_RESULT},
        {1'b1, {REG_ENABLES, 48'h0000_0000_000F}, NO_WORD, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_SAMPLE, 12'hFFF, 32'h0000_0007, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT},
        {1'b0, NO_WRITE, {OP_READ, 12'h000, 32'h0000_0000, 4'h0, 2'd0, 2'd0}, 1'b0, IDLE_RESULT}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] padded(input logic [CFG_DATA_BITS-1:0] v,
                                                        input int bits);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = CFG_DATA_BITS'({$urandom(), $urandom()});
        if ($urandom_range(0, 1) == 0)
        begin
            junk = '0;
        end
        return (junk << bits) | v;
    endfunction

    task automatic step_trigger_bank(input word_t w, output result_t r);
        logic [SAMPLE_BITS-1:0] thr;
        bit above;
        bit below;
        r = '0;
        case (w.op)
            OP_SAMPLE:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (en_bits[s])
                    begin
                        thr   = thr_bits[s*SAMPLE_BITS +: SAMPLE_BITS];
                        above = int'(w.sample) > int'(thr) + int'(band_w);
                        below = int'(w.sample) + int'(band_w) < int'(thr);
                        if (armed_slots[s])
                        begin
                            if (rise_bits[s] ? above : below)
                            begin
                                armed_slots[s]  = 1'b0;
                                sticky_flags[s] = 1'b1;
                                r.fired_mask[s] = 1'b1;
                                for (int d = HISTORY_DEPTH - 1; d > 0; d--)
                                begin
                                    fire_times[s][d] = fire_times[s][d-1];
                                end
                                fire_times[s][0] = w.timestamp;
                                // slots are walked upward, so the highest one wins
                                if (gpio_act_bits[s])
                                begin
                                    r.gpio_write = 1'b1;
                                    r.gpio_level = gpio_lvl_bits[s];
                                end
                            end
                        end
                        else if (rise_bits[s] ? below : above)
                        begin
                            armed_slots[s] = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                sticky_flags = sticky_flags & ~w.clear_mask;
            end
            OP_READ:
            begin
                if (int'(w.slot) < SLOTS && int'(w.time_index) < HISTORY_DEPTH)
                begin
                    r.event_time = fire_times[w.slot][w.time_index];
                end
            end
            default:
            begin
            end
        endcase
        r.triggered_flags = sticky_flags;
    endtask

    task automatic compare_result(input result_t want);
        if (results_if.triggered_flags !== want.triggered_flags)
        begin
            $error("triggered_flags: expected %0h, got %0h", want.triggered_flags,
                   results_if.triggered_flags);
            mismatches++;
        end
        if (results_if.fired_mask !== want.fired_mask)
        begin
            $error("fired_mask: expected %0h, got %0h", want.fired_mask, results_if.fired_mask);
            mismatches++;
        end
        if (results_if.gpio_write !== want.gpio_write)
        begin
            $error("gpio_write: expected %0h, got %0h", want.gpio_write, results_if.gpio_write);
            mismatches++;
        end
        if (results_if.gpio_level !== want.gpio_level)
        begin
            $error("gpio_level: expected %0h, got %0h", want.gpio_level, results_if.gpio_level);
            mismatches++;
        end
        if (results_if.event_time !== want.event_time)
        begin
            $error("event_time: expected %0h, got %0h", want.event_time, results_if.event_time);
            mismatches++;
        end
    endtask

    // watches both channels and the register port at every edge
    always @(posedge clk)
    begin
        word_t   w;
        result_t r;
        pin_t    p;
        if (!rst_n)
        begin
            thr_bits      = '0;
            band_w        = '0;
            en_bits       = '0;
            rise_bits     = '0;
            gpio_act_bits = '0;
            gpio_lvl_bits = '0;
            armed_slots   = '0;
            sticky_flags  = '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                for (int d = 0; d < HISTORY_DEPTH; d++)
                begin
                    fire_times[s][d] = '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                n_writes++;
                case (cfg_index)
                    REG_THRESHOLDS:
                    begin
                        thr_bits    = cfg_data[THR_BITS-1:0];
                        armed_slots = '0;
                    end
                    REG_NOISE_BAND:  band_w        = cfg_data[BAND_BITS-1:0];
                    REG_ENABLES:     en_bits       = cfg_data[SLOTS-1:0];
                    REG_RISING:      rise_bits     = cfg_data[SLOTS-1:0];
                    REG_GPIO_ACTION: gpio_act_bits = cfg_data[SLOTS-1:0];
                    REG_GPIO_LEVELS: gpio_lvl_bits = cfg_data[SLOTS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (results_if.valid && results_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing pending");
                    mismatches++;
                end
                else
                begin
                    compare_result(expected_results.pop_front());
                end
            end
            if (items_if.valid && items_if.ready)
            begin
                w = {items_if.op, items_if.sample, items_if.timestamp, items_if.clear_mask,
                     items_if.slot, items_if.time_index};
                step_trigger_bank(w, r);
                n_words++;
                if (r.fired_mask != '0)
                begin
                    n_fired++;
                end
                if (w.op == OP_READ)
                begin
                    n_reads++;
                end
                if (pinned_q.size() == 0)
                begin
                    $error("input word taken that was never offered");
                    mismatches++;
                    expected_results.push_back(r);
                end
                else
                begin
                    p = pinned_q.pop_front();
                    expected_results.push_back(p.pinned ? p.want : r);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_wait > 0)
        begin
            results_if.ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
        begin
            results_if.ready <= 1'b1;
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                rx_wait <= pick_gap();
            end
        end
    end

    task automatic send_word(input word_t w, input logic pinned, input result_t want);
        int gap;
        gap = 0;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            gap = pick_gap();
        end
        if (cfg_we)
        begin
            cfg_we <= 1'b0;
        end
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pinned_q.push_back({pinned, want});
        items_if.valid      <= 1'b1;
        items_if.op         <= w.op;
        items_if.sample     <= w.sample;
        items_if.timestamp  <= w.timestamp;
        items_if.clear_mask <= w.clear_mask;
        items_if.slot       <= w.slot;
        items_if.time_index <= w.time_index;
        do @(posedge clk); while (!items_if.ready);
    endtask

    // stop offering words and wait for every result still owed
    task automatic drain();
        items_if.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        if (items_if.valid)
        begin
            drain();
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    function automatic word_t random_word();
        word_t w;
        int    p;
        int    s;
        int    v;
        p = $urandom_range(0, 99);
        if (p < 78)
        begin
            w.op = OP_SAMPLE;
        end
        else if (p < 88)
        begin
            w.op = OP_READ;
        end
        else if (p < 96)
        begin
            w.op = OP_CLEAR;
        end
        else
        begin
            w.op = OP_UNUSED;
        end
        // half of the samples land just inside or just outside a slot's band
        p = $urandom_range(0, 99);
        if (p < 50)
        begin
            s = $urandom_range(0, SLOTS - 1);
            v = int'(band_w) + $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0)
            begin
                v = -v;
            end
            v = v + int'(thr_bits[s*SAMPLE_BITS +: SAMPLE_BITS]);
            if (v < 0)
            begin
                v = 0;
            end
            if (v > (1 << SAMPLE_BITS) - 1)
            begin
                v = (1 << SAMPLE_BITS) - 1;
            end
        end
        else if (p < 62)
        begin
            v = ($urandom_range(0, 1) == 0) ? 0 : (1 << SAMPLE_BITS) - 1;
        end
        else
        begin
            v = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
        end
        w.sample     = SAMPLE_BITS'(v);
        w.timestamp  = TIME_BITS'($urandom());
        w.clear_mask = SLOTS'($urandom());
        w.slot       = SLOT_BITS'($urandom());
        w.time_index = TIDX_BITS'($urandom());
        return w;
    endfunction

    initial
    begin
        logic [THR_BITS-1:0]  thr;
        logic [BAND_BITS-1:0] band;
        logic [SLOTS-1:0]     en;
        logic [SLOTS-1:0]     rise;
        logic [SLOTS-1:0]     act;
        logic [SLOTS-1:0]     lvl;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        items_if.valid      = 1'b0;
        items_if.op         = OP_SAMPLE;
        items_if.sample     = '0;
        items_if.timestamp  = '0;
        items_if.clear_mask = '0;
        items_if.slot       = '0;
        items_if.time_index = '0;
        results_if.ready    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                write_reg(dir_rows[i].wr.idx, dir_rows[i].wr.data);
            end
            else
            begin
                send_word(dir_rows[i].w, dir_rows[i].pinned, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // one phase runs with both sides flat out
            tx_gap_pct   = (ph == 3) ? 0 : 10 * $urandom_range(1, 6);
            rx_stall_pct = (ph == 3) ? 0 : 10 * $urandom_range(1, 6);
            drain();
            case (ph)
                0:
                begin
                    thr  = '0;
                    band = '0;
                    en   = '1;
                    rise = '1;
                    act  = '1;
                    lvl  = '0;
                end
                1:
                begin
                    thr  = '1;
                    band = '1;
                    en   = '1;
                    rise = '0;
                    act  = '1;
                    lvl  = '1;
                end
                2:
                begin
                    thr  = 48'h000_FFF_001_FFE;
                    band = '0;
                    en   = '1;
                    rise = 4'h6;
                    act  = 4'h9;
                    lvl  = 4'h3;
                end
                default:
                begin
                    thr  = THR_BITS'({$urandom(), $urandom()});
                    band = ($urandom_range(0, 9) == 0) ? BAND_BITS'($urandom())
                                                        : BAND_BITS'($urandom_range(0, 300));
                    en   = ($urandom_range(0, 2) == 0) ? SLOTS'($urandom()) : '1;
                    rise = SLOTS'($urandom());
                    act  = SLOTS'($urandom());
                    lvl  = SLOTS'($urandom());
                end
            endcase
            // some phases leave the thresholds alone so arms carry over
            if (ph < 3 || ph % 2 == 1)
            begin
                write_reg(REG_THRESHOLDS, thr);
            end
            write_reg(REG_NOISE_BAND, padded(CFG_DATA_BITS'(band), BAND_BITS));
            write_reg(REG_ENABLES, padded(CFG_DATA_BITS'(en), SLOTS));
            write_reg(REG_RISING, padded(CFG_DATA_BITS'(rise), SLOTS));
            write_reg(REG_GPIO_ACTION, padded(CFG_DATA_BITS'(act), SLOTS));
            write_reg(REG_GPIO_LEVELS, padded(CFG_DATA_BITS'(lvl), SLOTS));
            if (ph == 5)
            begin
                write_reg(REG_SPARE_HI, CFG_DATA_BITS'({$urandom(), $urandom()}));
            end
            repeat (RAND_WORDS) send_word(random_word(), 1'b0, IDLE_RESULT);
        end

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d words and %0d register writes: %0d results with a firing,",
                 n_words, n_writes, n_fired);
        $display("%0d history reads, %0d settings phases under random stalls", n_reads,
                 RAND_PHASES + 1);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
